>>> hw/rtl/cqli_pkg.sv
// shared types and constants for the conservative quartic line interpolator
// used by cqli_cell, cqli_datapath and conservative_quartic_line_interp
// no dependencies
package cqli_pkg;

   // sample width follows the data width, clamped to the 32-bit field
   localparam int DATA_WIDTH   = 32;
   localparam int SAMPLE_BITS  = (DATA_WIDTH < 16) ? 16 :
                                 ((DATA_WIDTH > 32) ? 32 : DATA_WIDTH);
   localparam int FIELD_BITS   = 32;

   // window of previous samples
   localparam int WINDOW_DEPTH = 4;
   localparam int FILL_BITS    = 3;

   // limiter coefficient, unsigned Q0.10
   localparam int COEFF_BITS = 10;
   localparam logic [COEFF_BITS-1:0] COEFF_RESET = COEFF_BITS'(512);

   // slope kept in units of 2^-10 sample lsb
   localparam int FRAC_BITS   = 10;
   localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);
   localparam int DIFF_BITS   = SAMPLE_BITS + 1;
   localparam int T1_BITS     = DIFF_BITS + 2;
   localparam int T2_BITS     = DIFF_BITS + 5;
   localparam int SLOPE_BITS  = SAMPLE_BITS + 10;
   localparam int MAG_BITS    = SLOPE_BITS;
   localparam int ACC_BITS    = SAMPLE_BITS + 12;
   localparam int SLOPE_SHIFT = 3;
   localparam int REPL_SHIFT  = 7;

   // configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = COEFF_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MONOTONIC_ENABLE = 1'b0,
      CSR_LIMITER_COEFF    = 1'b1
   } cqli_csr_index_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] coarse_sample;
      logic                         line_last;
   } cqli_req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] fine_low;
      logic signed [FIELD_BITS-1:0] fine_high;
      logic                         line_done;
   } cqli_rsp_type;

   typedef struct packed {
      logic                  monotonic_enable;
      logic [COEFF_BITS-1:0] limiter_coeff;
   } cqli_cfg_type;

   // window taps, oldest first
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] l2;
      logic signed [SAMPLE_BITS-1:0] l1;
      logic signed [SAMPLE_BITS-1:0] c;
      logic signed [SAMPLE_BITS-1:0] r1;
   } cqli_window_type;

endpackage

>>> hw/rtl/cqli_cell.sv
// one tap of the sample window chain: holds a sample, takes its neighbour's
// depends on cqli_pkg
module cqli_cell import cqli_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_en,
   input  logic                          clear,
   input  logic signed [SAMPLE_BITS-1:0] neighbour_sample,
   output logic signed [SAMPLE_BITS-1:0] held_sample
);

   logic signed [SAMPLE_BITS-1:0] tap_ff;
   logic signed [SAMPLE_BITS-1:0] tap_in;

   // shift in from the neighbour, empty at the end of a line
   always_comb begin
      tap_in = tap_ff;
      if (shift_en) begin
         tap_in = clear ? '0 : neighbour_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_in;
      end
   end

   assign held_sample = tap_ff;

endmodule

>>> hw/rtl/cqli_datapath.sv
// six-stage slope, limiter and rounding pipeline with per-stage valid
// depends on cqli_pkg
module cqli_datapath import cqli_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  cqli_cfg_type                  cfg,
   input  logic                          in_valid,
   input  logic                          in_last,
   input  cqli_window_type               window,
   input  logic signed [SAMPLE_BITS-1:0] newest,
   output logic                          in_ready,
   output logic                          rsp_valid,
   output cqli_rsp_type                  rsp_data,
   input  logic                          rsp_stall
);

   localparam logic signed [ACC_BITS-1:0] SAT_MAX =
      (ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] SAT_MIN = -SAT_MAX - ACC_BITS'(1);

   // round to nearest, ties upward, then saturate to the sample range
   function automatic logic signed [FIELD_BITS-1:0] round_sat(
      input logic signed [ACC_BITS-1:0] acc
   );
      logic signed [ACC_BITS-1:0] q;
      q = acc >>> FRAC_BITS;
      if (q > SAT_MAX) begin
         q = SAT_MAX;
      end else if (q < SAT_MIN) begin
         q = SAT_MIN;
      end
      return FIELD_BITS'($signed(q[SAMPLE_BITS-1:0]));
   endfunction

   // stage ready chain: a stage loads when empty or when its successor moves
   logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;
   logic v_a_ff, v_b_ff, v_c_ff, v_d_ff, v_e_ff, v_f_ff;

   assign rdy_f    = !v_f_ff || !rsp_stall;
   assign rdy_e    = !v_e_ff || rdy_f;
   assign rdy_d    = !v_d_ff || rdy_e;
   assign rdy_c    = !v_c_ff || rdy_d;
   assign rdy_b    = !v_b_ff || rdy_c;
   assign rdy_a    = !v_a_ff || rdy_b;
   assign in_ready = rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
         v_c_ff <= 1'b0;
         v_d_ff <= 1'b0;
         v_e_ff <= 1'b0;
         v_f_ff <= 1'b0;
      end else begin
         if (rdy_a) v_a_ff <= in_valid;
         if (rdy_b) v_b_ff <= v_a_ff;
         if (rdy_c) v_c_ff <= v_b_ff;
         if (rdy_d) v_d_ff <= v_c_ff;
         if (rdy_e) v_e_ff <= v_d_ff;
         if (rdy_f) v_f_ff <= v_e_ff;
      end
   end

   // stage a: neighbour differences
   logic signed [SAMPLE_BITS-1:0] a_c_ff;
   logic                          a_last_ff;
   logic signed [DIFF_BITS-1:0]   a_d1_ff, a_d2_ff, a_dl_ff, a_dr_ff;
   logic signed [DIFF_BITS-1:0]   a_d1_in, a_d2_in, a_dl_in, a_dr_in;

   always_comb begin
      a_d1_in = DIFF_BITS'(window.l2) - DIFF_BITS'(newest);
      a_d2_in = DIFF_BITS'(window.r1) - DIFF_BITS'(window.l1);
      a_dl_in = DIFF_BITS'(window.c)  - DIFF_BITS'(window.l1);
      a_dr_in = DIFF_BITS'(window.r1) - DIFF_BITS'(window.c);
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         a_c_ff    <= window.c;
         a_last_ff <= in_last;
         a_d1_ff   <= a_d1_in;
         a_d2_ff   <= a_d2_in;
         a_dl_ff   <= a_dl_in;
         a_dr_ff   <= a_dr_in;
      end
   end

   // stage b: weighted terms, limiter bounds and sign tests
   logic signed [SAMPLE_BITS-1:0] b_c_ff;
   logic                          b_last_ff;
   logic signed [DIFF_BITS-1:0]   b_d2_ff;
   logic signed [T1_BITS-1:0]     b_t1_ff, b_t1_in;
   logic signed [T2_BITS-1:0]     b_t2_ff, b_t2_in;
   logic [MAG_BITS-1:0]           b_lim_l_ff, b_lim_l_in, b_lim_r_ff, b_lim_r_in;
   logic                          b_same_ff, b_same_in, b_neg_ff, b_neg_in;
   logic signed [DIFF_BITS-1:0]   abs_dl, abs_dr;
   logic signed [T1_BITS-1:0]     d1_wide;
   logic signed [T2_BITS-1:0]     d2_wide;

   always_comb begin
      d1_wide    = T1_BITS'(a_d1_ff);
      d2_wide    = T2_BITS'(a_d2_ff);
      b_t1_in    = d1_wide + (d1_wide <<< 1);
      b_t2_in    = (d2_wide <<< 4) + (d2_wide <<< 2) + (d2_wide <<< 1);
      abs_dl     = a_dl_ff[DIFF_BITS-1] ? -a_dl_ff : a_dl_ff;
      abs_dr     = a_dr_ff[DIFF_BITS-1] ? -a_dr_ff : a_dr_ff;
      b_lim_l_in = MAG_BITS'(abs_dl[SAMPLE_BITS-1:0]) * MAG_BITS'(cfg.limiter_coeff);
      b_lim_r_in = MAG_BITS'(abs_dr[SAMPLE_BITS-1:0]) * MAG_BITS'(cfg.limiter_coeff);
      b_same_in  = ((a_dl_ff > 0) && (a_dr_ff > 0)) || ((a_dl_ff < 0) && (a_dr_ff < 0));
      b_neg_in   = a_dl_ff < 0;
   end

   always_ff @(posedge clock) begin
      if (rdy_b) begin
         b_c_ff     <= a_c_ff;
         b_last_ff  <= a_last_ff;
         b_d2_ff    <= a_d2_ff;
         b_t1_ff    <= b_t1_in;
         b_t2_ff    <= b_t2_in;
         b_lim_l_ff <= b_lim_l_in;
         b_lim_r_ff <= b_lim_r_in;
         b_same_ff  <= b_same_in;
         b_neg_ff   <= b_neg_in;
      end
   end

   // stage c: quartic slope
   logic signed [SAMPLE_BITS-1:0] c_c_ff;
   logic                          c_last_ff;
   logic signed [DIFF_BITS-1:0]   c_d2_ff;
   logic signed [SLOPE_BITS-1:0]  c_s_ff, c_s_in;
   logic [MAG_BITS-1:0]           c_lim_l_ff, c_lim_r_ff;
   logic                          c_same_ff, c_neg_ff;

   assign c_s_in = (SLOPE_BITS'(b_t1_ff) + SLOPE_BITS'(b_t2_ff)) <<< SLOPE_SHIFT;

   always_ff @(posedge clock) begin
      if (rdy_c) begin
         c_c_ff     <= b_c_ff;
         c_last_ff  <= b_last_ff;
         c_d2_ff    <= b_d2_ff;
         c_s_ff     <= c_s_in;
         c_lim_l_ff <= b_lim_l_ff;
         c_lim_r_ff <= b_lim_r_ff;
         c_same_ff  <= b_same_ff;
         c_neg_ff   <= b_neg_ff;
      end
   end

   // stage d: slope magnitude, with the central difference for a wrong sign
   logic signed [SAMPLE_BITS-1:0] d_c_ff;
   logic                          d_last_ff;
   logic [MAG_BITS-1:0]           d_mag_ff, d_mag_in;
   logic                          d_neg_ff, d_neg_in, d_limit_ff, d_limit_in;
   logic [MAG_BITS-1:0]           d_lim_l_ff, d_lim_r_ff;
   logic signed [SLOPE_BITS-1:0]  s_repl, s_sel, s_abs;
   logic                          s_opposite, sel_neg;

   always_comb begin
      s_repl     = SLOPE_BITS'(c_d2_ff) <<< REPL_SHIFT;
      s_opposite = c_neg_ff ? (c_s_ff > 0) : (c_s_ff < 0);
      s_sel      = (cfg.monotonic_enable && c_same_ff && s_opposite) ? s_repl : c_s_ff;
      sel_neg    = s_sel < 0;
      s_abs      = sel_neg ? -s_sel : s_sel;
      if (!cfg.monotonic_enable) begin
         d_mag_in   = MAG_BITS'(s_abs);
         d_neg_in   = sel_neg;
         d_limit_in = 1'b0;
      end else if (!c_same_ff) begin
         d_mag_in   = '0;
         d_neg_in   = 1'b0;
         d_limit_in = 1'b0;
      end else begin
         d_mag_in   = MAG_BITS'(s_abs);
         d_neg_in   = c_neg_ff;
         d_limit_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_d) begin
         d_c_ff     <= c_c_ff;
         d_last_ff  <= c_last_ff;
         d_mag_ff   <= d_mag_in;
         d_neg_ff   <= d_neg_in;
         d_limit_ff <= d_limit_in;
         d_lim_l_ff <= c_lim_l_ff;
         d_lim_r_ff <= c_lim_r_ff;
      end
   end

   // stage e: clamp against both neighbour bounds, restore the sign
   logic signed [SAMPLE_BITS-1:0] e_c_ff;
   logic                          e_last_ff;
   logic signed [SLOPE_BITS-1:0]  e_s_ff, e_s_in;
   logic [MAG_BITS-1:0]           m_clamped;

   always_comb begin
      m_clamped = d_mag_ff;
      if (d_limit_ff) begin
         if (d_lim_l_ff < m_clamped) m_clamped = d_lim_l_ff;
         if (d_lim_r_ff < m_clamped) m_clamped = d_lim_r_ff;
      end
      e_s_in = d_neg_ff ? -$signed(m_clamped) : $signed(m_clamped);
   end

   always_ff @(posedge clock) begin
      if (rdy_e) begin
         e_c_ff    <= d_c_ff;
         e_last_ff <= d_last_ff;
         e_s_ff    <= e_s_in;
      end
   end

   // stage f: fine values, rounded and saturated, held as the output register
   logic signed [ACC_BITS-1:0] centre_scaled, acc_low, acc_high;
   cqli_rsp_type               f_rsp_ff, f_rsp_in;

   always_comb begin
      centre_scaled      = ACC_BITS'(e_c_ff) <<< FRAC_BITS;
      acc_low            = centre_scaled - ACC_BITS'(e_s_ff) + ACC_BITS'(ROUND_HALF);
      acc_high           = centre_scaled + ACC_BITS'(e_s_ff) + ACC_BITS'(ROUND_HALF);
      f_rsp_in.fine_low  = round_sat(acc_low);
      f_rsp_in.fine_high = round_sat(acc_high);
      f_rsp_in.line_done = e_last_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy_f) begin
         f_rsp_ff <= f_rsp_in;
      end
   end

   assign rsp_valid = v_f_ff;
   assign rsp_data  = f_rsp_ff;

endmodule

>>> hw/rtl/conservative_quartic_line_interp.sv
// Conservative quartic 2x line refinement, one sample per cycle unless stalled.
//
// Input channel req_*: one coarse sample (signed Q16.16) per transaction, with
// line_last on the final sample of a line, ghost cells included. Result channel
// rsp_*: from the fifth sample of a line onward each transaction gives the
// pair of fine values of the window centre and line_done; shorter lines give
// nothing. Configuration port csr_*: index 0 monotonic_enable, index 1
// limiter_coeff; csr_ready is always high; write only while the block is idle.
//
// Throughput is one transaction per cycle in both directions when neither side
// stalls. A sample passes through the six registered stages of the datapath
// (differences, weighted terms and limiter bounds, slope, magnitude selection,
// clamping, rounding into the output register), the first of which loads at
// the accepting edge. The window is a chain of four cells that shifts on every
// accepted sample.
// When the receiver stalls the output register holds its transaction, empty
// stages behind it keep filling, and req_stall rises once no stage is free.
// Synchronous reset empties the pipeline and the window, and sets
// monotonic_enable to 0 and limiter_coeff to 512.
//
// depends on cqli_pkg, cqli_cell, cqli_datapath
module conservative_quartic_line_interp import cqli_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cqli_req_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cqli_rsp_type              rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   // configuration registers
   logic                  monotonic_enable_ff, monotonic_enable_in;
   logic [COEFF_BITS-1:0] limiter_coeff_ff, limiter_coeff_in;
   cqli_cfg_type          cfg;

   assign csr_ready = 1'b1;

   always_comb begin
      monotonic_enable_in = monotonic_enable_ff;
      limiter_coeff_in    = limiter_coeff_ff;
      if (csr_valid && csr_ready) begin
         case (cqli_csr_index_type'(csr_index))
            CSR_MONOTONIC_ENABLE: begin
               monotonic_enable_in = csr_data[0];
            end
            CSR_LIMITER_COEFF: begin
               limiter_coeff_in = csr_data[COEFF_BITS-1:0];
            end
            default: begin
               monotonic_enable_in = monotonic_enable_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         monotonic_enable_ff <= 1'b0;
         limiter_coeff_ff    <= COEFF_RESET;
      end else begin
         monotonic_enable_ff <= monotonic_enable_in;
         limiter_coeff_ff    <= limiter_coeff_in;
      end
   end

   assign cfg.monotonic_enable = monotonic_enable_ff;
   assign cfg.limiter_coeff    = limiter_coeff_ff;

   // input transaction
   logic                          dp_ready;
   logic                          req_accept;
   logic signed [SAMPLE_BITS-1:0] newest;

   assign req_stall  = !dp_ready;
   assign req_accept = req_valid && !req_stall;
   assign newest     = $signed(req_data.coarse_sample[SAMPLE_BITS-1:0]);

   // fill count of the window
   logic [FILL_BITS-1:0] fill_count_ff, fill_count_in;
   logic                 window_full;

   assign window_full = (fill_count_ff == FILL_BITS'(WINDOW_DEPTH));

   always_comb begin
      fill_count_in = fill_count_ff;
      if (req_accept) begin
         if (req_data.line_last) begin
            fill_count_in = '0;
         end else if (!window_full) begin
            fill_count_in = fill_count_ff + FILL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
      end else begin
         fill_count_ff <= fill_count_in;
      end
   end

   // window chain, oldest cell first, newest sample enters at the far end
   logic signed [SAMPLE_BITS-1:0] tap [WINDOW_DEPTH];
   cqli_window_type               window;

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] feed;
      if (i == WINDOW_DEPTH - 1) begin : g_end
         assign feed = newest;
      end else begin : g_mid
         assign feed = tap[i+1];
      end
      cqli_cell u_cell (
         .clock            (clock),
         .reset            (reset),
         .shift_en         (req_accept),
         .clear            (req_data.line_last),
         .neighbour_sample (feed),
         .held_sample      (tap[i])
      );
   end

   assign window.l2 = tap[0];
   assign window.l1 = tap[1];
   assign window.c  = tap[2];
   assign window.r1 = tap[3];

   // slope and rounding pipeline
   cqli_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid && window_full),
      .in_last   (req_data.line_last),
      .window    (window),
      .newest    (newest),
      .in_ready  (dp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // window bookkeeping checks
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= FILL_BITS'(WINDOW_DEPTH))
      else $error("fill count beyond window depth");

   a_line_restart: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.line_last |=> fill_count_ff == '0)
      else $error("window not restarted after end of line");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_data.line_last && !window_full
      |=> fill_count_ff == FILL_BITS'($past(fill_count_ff) + FILL_BITS'(1)))
      else $error("fill count did not advance on a sample");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for conservative_quartic_line_interp, with its own fine pair predictor
// depends on cqli_pkg and the rtl of conservative_quartic_line_interp
module testbench;
   import cqli_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;

   // predicts fine pairs from accepted coarse samples and checks them in order
   class refine_scoreboard;
      logic                  mono_on;
      logic [COEFF_BITS-1:0] coeff;
      longint                taps[WINDOW_DEPTH];
      int                    fill;
      cqli_rsp_type          pending_pairs[$];
      int                    errors;

      function new();
         mono_on = 1'b0;
         coeff   = COEFF_RESET;
         fill    = 0;
         errors  = 0;
         foreach (taps[i]) taps[i] = 0;
      endfunction

      function void set_register(cqli_csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_MONOTONIC_ENABLE: begin
               mono_on = value[0];
            end
            CSR_LIMITER_COEFF: begin
               coeff = value[COEFF_BITS-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      static function int sign_of(longint v);
         return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
      endfunction

      // round half up from 2^-10 units, then saturate to the sample range
      static function logic signed [FIELD_BITS-1:0] round_fine(longint scaled);
         longint r;
         longint hi;
         longint lo;
         hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
         lo = -hi - 1;
         r  = (scaled + ROUND_HALF) >>> FRAC_BITS;
         if (r > hi) r = hi;
         if (r < lo) r = lo;
         return r[FIELD_BITS-1:0];
      endfunction

      function void note_sample(cqli_req_type item);
         longint       x;
         longint       slope;
         longint       dl;
         longint       dr;
         longint       k;
         longint       mag;
         int           sl;
         int           sr;
         cqli_rsp_type pair;
         x = longint'($signed(item.coarse_sample[SAMPLE_BITS-1:0]));
         if (fill >= WINDOW_DEPTH) begin
            // quartic slope of the centre tap, in 2^-10 units
            slope = 8 * (3 * (taps[0] - x) + 22 * (taps[3] - taps[1]));
            if (mono_on) begin
               dl = taps[2] - taps[1];
               dr = taps[3] - taps[2];
               sl = sign_of(dl);
               sr = sign_of(dr);
               if (sl != 0 && sl == sr) begin
                  k = longint'(coeff);
                  // slope against the local trend falls back to the central difference
                  if (sign_of(slope) == -sl) slope = 128 * (taps[3] - taps[1]);
                  mag = sl * slope;
                  if (sl * dl * k < mag) mag = sl * dl * k;
                  if (sl * dr * k < mag) mag = sl * dr * k;
                  slope = sl * mag;
               end else begin
                  slope = 0;
               end
            end
            pair.fine_low  = round_fine(taps[2] * 1024 - slope);
            pair.fine_high = round_fine(taps[2] * 1024 + slope);
            pair.line_done = item.line_last;
            pending_pairs.push_back(pair);
         end
         // shift the window, restart it at the end of a line
         for (int i = 0; i < WINDOW_DEPTH - 1; i++) taps[i] = taps[i + 1];
         taps[WINDOW_DEPTH - 1] = x;
         if (fill < WINDOW_DEPTH) fill++;
         if (item.line_last) begin
            foreach (taps[i]) taps[i] = 0;
            fill = 0;
         end
      endfunction

      function void check_pair(cqli_rsp_type got);
         cqli_rsp_type want;
         if (pending_pairs.size() == 0) begin
            $error("unexpected fine pair: fine_low %0d fine_high %0d line_done %0b",
                   got.fine_low, got.fine_high, got.line_done);
            errors++;
            return;
         end
         want = pending_pairs.pop_front();
         if (got.fine_low !== want.fine_low) begin
            $error("fine_low: expected %0d, got %0d", want.fine_low, got.fine_low);
            errors++;
         end
         if (got.fine_high !== want.fine_high) begin
            $error("fine_high: expected %0d, got %0d", want.fine_high, got.fine_high);
            errors++;
         end
         if (got.line_done !== want.line_done) begin
            $error("line_done: expected %0b, got %0b", want.line_done, got.line_done);
            errors++;
         end
      endfunction
   endclass

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_valid  = 1'b0;
   logic                     req_stall;
   cqli_req_type             req_data   = '0;
   logic                     rsp_valid;
   logic                     rsp_stall  = 1'b0;
   cqli_rsp_type             rsp_data;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   cqli_csr_index_type       csr_index  = CSR_MONOTONIC_ENABLE;
   logic [CSR_DATA_BITS-1:0] csr_data   = '0;

   int send_idle  = 0;
   int recv_stall = 0;
   int cycles     = 0;

   refine_scoreboard sb = new();

   conservative_quartic_line_interp dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: check each accepted transaction, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_pair(rsp_data);
      rsp_stall <= ($urandom_range(99) < recv_stall);
   end

   task automatic send_sample(cqli_req_type item);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_sample(item);
   endtask

   task automatic send_fixed_line(int values[$]);
      cqli_req_type item;
      foreach (values[i]) begin
         item.coarse_sample = values[i];
         item.line_last     = (i == values.size() - 1);
         send_sample(item);
      end
   endtask

   // one line of samples: random words, ramps with curvature, or range extremes
   task automatic send_line(int len);
      int           mode;
      logic [31:0]  base;
      logic [31:0]  step;
      logic [31:0]  curve;
      logic [31:0]  value;
      cqli_req_type item;
      mode  = $urandom_range(9);
      base  = $urandom;
      step  = (mode >= 7) ? $urandom_range(0, 1 << 29) - (1 << 28)
                          : $urandom_range(0, 1 << 17) - (1 << 16);
      curve = $urandom_range(0, 1 << 13) - (1 << 12);
      for (int i = 0; i < len; i++) begin
         if (mode <= 1) begin
            value = $urandom;
         end else if (mode == 9) begin
            case ($urandom_range(6))
               0: value = 32'h7fffffff;
               1: value = 32'h80000000;
               2: value = 32'h00000000;
               3: value = 32'hffffffff;
               4: value = 32'h00000001;
               5: value = 32'h7ffffffe;
               default: value = 32'h80000001;
            endcase
         end else begin
            value = base + step * i + curve * i * i;
            if ($urandom_range(15) == 0) value = value + $urandom_range(0, 2047) - 1024;
         end
         item.coarse_sample = value;
         item.line_last     = (i == len - 1);
         send_sample(item);
      end
   endtask

   // both registers in one burst so csr_valid stays high between them
   task automatic configure(logic mono, logic [COEFF_BITS-1:0] coeff);
      logic [CSR_DATA_BITS-1:0] mono_word;
      mono_word    = CSR_DATA_BITS'($urandom);
      mono_word[0] = mono;
      csr_valid <= 1'b1;
      csr_index <= CSR_MONOTONIC_ENABLE;
      csr_data  <= mono_word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(CSR_MONOTONIC_ENABLE, mono_word);
      csr_index <= CSR_LIMITER_COEFF;
      csr_data  <= coeff;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(CSR_LIMITER_COEFF, coeff);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.pending_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly full lines, some too short to give a result
   task automatic run_phase(logic mono, logic [COEFF_BITS-1:0] coeff, int n_items);
      int sent;
      int len;
      sent = 0;
      configure(mono, coeff);
      while (sent < n_items) begin
         len = ($urandom_range(99) < 15) ? $urandom_range(1, 4) : $urandom_range(5, 24);
         send_line(len);
         sent += len;
      end
      wait_drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short lines, window restart and saturation with reset settings
      send_fixed_line('{12345});
      send_fixed_line('{-5, 65536, 7});
      send_fixed_line('{32'h7fffffff, 32'h80000000, 32'h7fffffff,
                        32'h80000000, 32'h7fffffff, 32'h80000000});
      wait_drain();

      // directed limiter cases: reversed slope, clipped slope, local extremum
      configure(1'b1, 10'd1023);
      send_fixed_line('{-1000000, 0, 1, 2, 1000000});
      send_fixed_line('{0, 0, 1, 100000, 100000});
      send_fixed_line('{0, 65536, 10, 131072, -5000});
      wait_drain();

      // random lines, sender idling less than the receiver stalls
      send_idle  = 34;
      recv_stall = 55;
      run_phase(1'b0, 10'd0, 140);
      run_phase(1'b1, 10'd0, 140);

      // the other way round
      send_idle  = 55;
      recv_stall = 34;
      run_phase(1'b1, 10'd1023, 140);
      run_phase(1'b1, COEFF_BITS'($urandom_range(1, 1022)), 140);

      // full rate in both directions
      send_idle  = 0;
      recv_stall = 0;
      run_phase(1'b1, 10'd512, 140);
      run_phase(1'b0, 10'd1023, 140);

      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/cqli_pkg.sv
hw/rtl/cqli_cell.sv
hw/rtl/cqli_datapath.sv
hw/rtl/conservative_quartic_line_interp.sv
tb/testbench.sv
